[hdl/desc_pkg.sv]
// ----------------------------------------------------------------------------
// desc_pkg
// Types and constants shared by the dual encoder step counter.
// ----------------------------------------------------------------------------
package desc_pkg;

   localparam int HIST_W  = 13;
   localparam int STEP_W  = 3;
   localparam int COUNT_W = 10;
   localparam int VALUE_W = 12;

   typedef logic [1:0]          pins_type;
   typedef logic [7:0]          raw_type;
   typedef logic [1:0]          enc_type;
   typedef logic [HIST_W-1:0]   hist_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam hist_type  HIST_HIT  = 13'h1F00;
   localparam value_type WRAP_VAL  = 12'sd1023;
   localparam value_type VALUE_ZERO = 12'sd0;

   localparam enc_type ENC_TOP  = 2'b11;
   localparam enc_type ENC_UP   = 2'b01;
   localparam enc_type ENC_DOWN = 2'b10;

   localparam step_type STEP_RESET = 3'd1;
   localparam step_type STEP_BOTH  = 3'd0;
   localparam step_type STEP_ZERO  = 3'd2;
   localparam step_type STEP_ONE   = 3'd4;

endpackage

[hdl/desc_if.sv]
// ----------------------------------------------------------------------------
// desc_req_if / desc_rsp_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface desc_req_if;
   logic               valid;
   logic               ready;
   desc_pkg::pins_type button_pins;
   desc_pkg::raw_type  encoder_raw;

   modport source (output valid, output button_pins, output encoder_raw, input ready);
   modport sink   (input valid, input button_pins, input encoder_raw, output ready);
endinterface

interface desc_rsp_if;
   logic                valid;
   logic                ready;
   desc_pkg::step_type  shown_step;
   desc_pkg::step_type  step_now;
   desc_pkg::count_type count;

   modport source (output valid, output shown_step, output step_now, output count,
                   input ready);
   modport sink   (input valid, input shown_step, input step_now, input count,
                   output ready);
endinterface

[hdl/desc_debounce.sv]
// ----------------------------------------------------------------------------
// desc_debounce
// Shift-register debouncer for one active-low button; flags a press once.
// ----------------------------------------------------------------------------
module desc_debounce (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic level,
   output logic hit
);
   import desc_pkg::*;

   hist_type hist_ff;
   hist_type hist_in;

   assign hist_in = {hist_ff[HIST_W-2:0], level};
   assign hit     = (hist_in == HIST_HIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (advance) begin
         hist_ff <= hist_in;
      end
   end
endmodule

[hdl/desc_encoder.sv]
// ----------------------------------------------------------------------------
// desc_encoder
// Applies one encoder transition to the running count by the current step.
// ----------------------------------------------------------------------------
module desc_encoder (
   input  desc_pkg::enc_type   prev,
   input  desc_pkg::enc_type   cur,
   input  desc_pkg::step_type  step,
   input  desc_pkg::value_type value_i,
   output desc_pkg::value_type value_o
);
   import desc_pkg::*;

   value_type step_ext;

   assign step_ext = value_type'({{(VALUE_W-STEP_W){1'b0}}, step});

   always_comb begin
      if (cur == ENC_TOP && prev == ENC_UP) begin
         value_o = value_i + step_ext;
      end else if (cur == ENC_TOP && prev == ENC_DOWN) begin
         value_o = value_i - step_ext;
      end else begin
         value_o = value_i;
      end
   end
endmodule

[hdl/dual_encoder_step_counter.sv]
// ----------------------------------------------------------------------------
// dual_encoder_step_counter
// Two debounced buttons pick a step; two quadrature encoders move a count.
// ----------------------------------------------------------------------------
// Each input item is one sample tick: two active-low button levels and the
// encoder byte (left encoder in bits 1:0, right in bits 3:2). The item is
// captured in an input register; once the result register is free, the
// debouncers, step selection, both encoder updates and the wrap by 1023
// settle in one pass into the result register. Every item yields exactly
// one result, and a new item is taken every cycle while the result side
// keeps up. The first item after reset only seeds the encoder history, so
// the count does not move on it.
// ----------------------------------------------------------------------------
module dual_encoder_step_counter (
   input  logic              clock,
   input  logic              reset,
   desc_req_if.sink          req_chan,
   desc_rsp_if.source        rsp_chan
);
   import desc_pkg::*;

   logic      in_valid_ff;
   pins_type  in_pins_ff;
   raw_type   in_raw_ff;

   logic      out_valid_ff;
   step_type  out_shown_ff;
   step_type  out_step_ff;
   count_type out_count_ff;

   enc_type   prev_left_ff;
   enc_type   prev_right_ff;
   logic      seeded_ff;
   step_type  step_ff;
   step_type  step_in;
   count_type counter_ff;
   count_type counter_in;

   logic      advance;
   logic      out_free;
   logic      hit0;
   logic      hit1;
   enc_type   cur_left;
   enc_type   cur_right;
   enc_type   prev_left_eff;
   enc_type   prev_right_eff;
   value_type value_base;
   value_type value_left;
   value_type value_right;
   value_type value_wrap;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   desc_debounce u_deb0 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .level   (in_pins_ff[0]),
      .hit     (hit0)
   );

   desc_debounce u_deb1 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .level   (in_pins_ff[1]),
      .hit     (hit1)
   );

   always_comb begin
      if (hit0 && hit1) begin
         step_in = STEP_BOTH;
      end else if (hit0) begin
         step_in = STEP_ZERO;
      end else if (hit1) begin
         step_in = STEP_ONE;
      end else begin
         step_in = step_ff;
      end
   end

   assign cur_left       = in_raw_ff[1:0];
   assign cur_right      = in_raw_ff[3:2];
   assign prev_left_eff  = seeded_ff ? prev_left_ff  : cur_left;
   assign prev_right_eff = seeded_ff ? prev_right_ff : cur_right;
   assign value_base     = value_type'({{(VALUE_W-COUNT_W){1'b0}}, counter_ff});

   desc_encoder u_enc_left (
      .prev    (prev_left_eff),
      .cur     (cur_left),
      .step    (step_in),
      .value_i (value_base),
      .value_o (value_left)
   );

   desc_encoder u_enc_right (
      .prev    (prev_right_eff),
      .cur     (cur_right),
      .step    (step_in),
      .value_i (value_left),
      .value_o (value_right)
   );

   always_comb begin
      if (value_right < VALUE_ZERO) begin
         value_wrap = value_right + WRAP_VAL;
      end else if (value_right > WRAP_VAL) begin
         value_wrap = value_right - WRAP_VAL;
      end else begin
         value_wrap = value_right;
      end
   end

   assign counter_in = value_wrap[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         seeded_ff     <= 1'b0;
         step_ff       <= STEP_RESET;
         counter_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            prev_left_ff  <= cur_left;
            prev_right_ff <= cur_right;
            seeded_ff     <= 1'b1;
            step_ff       <= step_in;
            counter_ff    <= counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_pins_ff <= req_chan.button_pins;
         in_raw_ff  <= req_chan.encoder_raw;
      end
      if (advance) begin
         out_shown_ff <= step_ff;
         out_step_ff  <= step_in;
         out_count_ff <= counter_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.shown_step = out_shown_ff;
   assign rsp_chan.step_now   = out_step_ff;
   assign rsp_chan.count      = out_count_ff;
endmodule

[bench/dual_encoder_step_counter_tb.sv]
// ----------------------------------------------------------------------------
// dual_encoder_step_counter_tb
// Self-checking bench for the dual encoder step counter. A directed opening
// walks the count through both wrap points, the first-tick seeding and
// single and simultaneous button presses. Random episodes of clean presses,
// noisy buttons and quadrature sweeps follow. Every accepted tick is run
// through a local predictor, and each result is checked field by field in
// order, with random idling on both sides, a long result-side hold-off and
// a full drain pause.
// ----------------------------------------------------------------------------
module dual_encoder_step_counter_tb;
   import desc_pkg::*;

   typedef struct {
      pins_type pins;
      raw_type  raw;
      bit       drain_first;
   } tick_item_type;

   typedef struct packed {
      step_type  shown_step;
      step_type  step_now;
      count_type count;
   } reading_type;

   typedef enum {BTN_IDLE, BTN_PRESS, BTN_NOISE} btn_plan_type;

   localparam int RANDOM_TICKS = 850;
   localparam int CALM_FIRST   = 400;
   localparam int CALM_LAST    = 549;
   localparam int GAP_PCT      = 36;
   localparam int HOLD_AT      = 250;
   localparam int HOLD_CYCLES  = 80;
   localparam int MAX_REPORTS  = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   desc_req_if req ();
   desc_rsp_if rsp ();

   dual_encoder_step_counter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // {button_pins, encoder_raw}
   logic [9:0] directed_ticks [26] = '{
      10'h3FF, 10'h300, 10'h302, 10'h303, 10'h3F1,
      10'h003, 10'h001, 10'h003, 10'h009, 10'h00F,
      10'h004, 10'h00C, 10'h000,
      10'h301, 10'h303, 10'h300, 10'h300, 10'h300,
      10'h150, 10'h1A0, 10'h100, 10'h100, 10'h100, 10'h100, 10'h101, 10'h103
   };

   tick_item_type pending_ticks [$];
   reading_type   expected_readings [$];
   int         total_ticks;
   int         ticks_sent;
   int         readings_seen;
   int         hold_left;
   int         errors;

   hist_type  db_hist0;
   hist_type  db_hist1;
   enc_type   enc_prev_left;
   enc_type   enc_prev_right;
   bit        enc_seeded;
   step_type  cur_step;
   count_type cur_count;

   function automatic int quad_delta(enc_type prev, enc_type cur);
      if (cur == ENC_TOP && prev == ENC_UP) return int'(cur_step);
      if (cur == ENC_TOP && prev == ENC_DOWN) return -int'(cur_step);
      return 0;
   endfunction

   function automatic reading_type advance_counter(pins_type pins, raw_type raw);
      reading_type r;
      logic     hit0;
      logic     hit1;
      enc_type  left;
      enc_type  right;
      int       value;
      r.shown_step = cur_step;
      db_hist0 = {db_hist0[HIST_W-2:0], pins[0]};
      db_hist1 = {db_hist1[HIST_W-2:0], pins[1]};
      hit0 = (db_hist0 == HIST_HIT);
      hit1 = (db_hist1 == HIST_HIT);
      if (hit0 && hit1) cur_step = STEP_BOTH;
      else if (hit0) cur_step = STEP_ZERO;
      else if (hit1) cur_step = STEP_ONE;
      left  = raw[1:0];
      right = raw[3:2];
      if (!enc_seeded) begin
         enc_prev_left  = left;
         enc_prev_right = right;
         enc_seeded     = 1'b1;
      end
      value = int'(cur_count);
      value += quad_delta(enc_prev_left, left);
      enc_prev_left = left;
      value += quad_delta(enc_prev_right, right);
      enc_prev_right = right;
      if (value < 0) value += int'(WRAP_VAL);
      else if (value > int'(WRAP_VAL)) value -= int'(WRAP_VAL);
      cur_count   = count_type'(value);
      r.step_now  = cur_step;
      r.count     = cur_count;
      return r;
   endfunction

   // Walk one gray step in the given direction, with some stalls and jumps.
   function automatic enc_type quad_next(enc_type cur, logic [1:0] dir);
      logic [1:0] pos;
      int         roll;
      roll = $urandom_range(99);
      if (roll < 10) return enc_type'($urandom_range(3));
      if (roll < 22) return cur;
      pos = {cur[1], cur[1] ^ cur[0]} + dir;
      return {pos[1], pos[1] ^ pos[0]};
   endfunction

   function automatic btn_plan_type pick_plan();
      int roll;
      roll = $urandom_range(5);
      if (roll == 0) return BTN_IDLE;
      if (roll == 5) return BTN_NOISE;
      return BTN_PRESS;
   endfunction

   always #6 clock = ~clock;

   always @(posedge clock) begin : drive_ticks
      tick_item_type item;
      logic       offering;
      logic       go;
      int         gap;
      if (reset) begin
         req.valid       <= 1'b0;
         req.button_pins <= '0;
         req.encoder_raw <= '0;
      end else begin
         offering = req.valid;
         if (req.valid && req.ready) begin
            expected_readings.push_back(advance_counter(req.button_pins, req.encoder_raw));
            ticks_sent++;
            offering = 1'b0;
         end
         if (!offering) begin
            gap = (ticks_sent >= CALM_FIRST && ticks_sent <= CALM_LAST) ? 0 : GAP_PCT;
            go  = pending_ticks.size() != 0 && $urandom_range(99) >= gap;
            // hold until every expected result is back
            if (go && pending_ticks[0].drain_first && expected_readings.size() != 0)
               go = 1'b0;
            if (go) begin
               item = pending_ticks.pop_front();
               req.button_pins <= item.pins;
               req.encoder_raw <= item.raw;
            end
            req.valid <= go;
         end
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      int       stall;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result shown_step=%0d step_now=%0d count=%0d",
                           $time, rsp.shown_step, rsp.step_now, rsp.count);
            end else begin
               want = expected_readings.pop_front();
               if (rsp.shown_step !== want.shown_step) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: shown_step expected %0d actual %0d",
                              $time, want.shown_step, rsp.shown_step);
               end
               if (rsp.step_now !== want.step_now) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: step_now expected %0d actual %0d",
                              $time, want.step_now, rsp.step_now);
               end
               if (rsp.count !== want.count) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: count expected %0d actual %0d",
                              $time, want.count, rsp.count);
               end
            end
            readings_seen++;
            if (readings_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         stall = (readings_seen >= CALM_FIRST && readings_seen <= CALM_LAST) ? 0 : GAP_PCT;
         rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= stall);
      end
   end

   initial begin
      #(12 * 200000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : run_ticks
      tick_item_type t;
      btn_plan_type  plan0;
      btn_plan_type  plan1;
      int         ep_len;
      int         hi0;
      int         lo0;
      int         hi1;
      int         lo1;
      int         n_random;
      logic [1:0] dir_l;
      logic [1:0] dir_r;
      enc_type    left;
      enc_type    right;

      req.valid       = 1'b0;
      req.button_pins = '0;
      req.encoder_raw = '0;
      rsp.ready       = 1'b0;

      db_hist0       = '0;
      db_hist1       = '0;
      enc_prev_left  = '0;
      enc_prev_right = '0;
      enc_seeded     = 1'b0;
      cur_step       = STEP_RESET;
      cur_count      = '0;
      ticks_sent     = 0;
      readings_seen  = 0;
      hold_left      = 0;
      errors         = 0;

      foreach (directed_ticks[i]) begin
         t.pins        = directed_ticks[i][9:8];
         t.raw         = directed_ticks[i][7:0];
         t.drain_first = 1'b0;
         pending_ticks.push_back(t);
      end

      left     = ENC_TOP;
      right    = '0;
      n_random = 0;
      while (n_random < RANDOM_TICKS) begin
         ep_len = $urandom_range(22, 13);
         plan0  = pick_plan();
         plan1  = pick_plan();
         hi0    = $urandom_range(7, 5);
         lo0    = $urandom_range(12, 8);
         hi1    = $urandom_range(7, 5);
         lo1    = $urandom_range(12, 8);
         if (plan0 == BTN_PRESS && plan1 == BTN_PRESS && $urandom_range(2) == 0) begin
            hi1 = hi0;
            lo1 = lo0;
         end
         dir_l = $urandom_range(1) ? 2'd1 : 2'd3;
         dir_r = $urandom_range(1) ? 2'd1 : 2'd3;
         for (int k = 0; k < ep_len; k++) begin
            t.pins[0] = (plan0 == BTN_NOISE) ? 1'($urandom_range(1))
                      : !(plan0 == BTN_PRESS && k >= hi0 && k < hi0 + lo0);
            t.pins[1] = (plan1 == BTN_NOISE) ? 1'($urandom_range(1))
                      : !(plan1 == BTN_PRESS && k >= hi1 && k < hi1 + lo1);
            left  = quad_next(left, dir_l);
            right = quad_next(right, dir_r);
            t.raw = {4'($urandom_range(15)), right, left};
            t.drain_first = (n_random == 600);
            pending_ticks.push_back(t);
            n_random++;
         end
      end
      total_ticks = pending_ticks.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (ticks_sent < total_ticks || expected_readings.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
